FILE: rtl/core/mmss_countdown_timer_assert.svh
// ----------------------------------------------------------------------------
// mmss_countdown_timer_assert.svh
// Assertion macros for the countdown timer, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef MMSS_COUNTDOWN_TIMER_ASSERT_SVH
`define MMSS_COUNTDOWN_TIMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property held at every clock edge out of reset
`define MCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MCT_ASSERT(lbl, prop, msg)
`define MCT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Types and constants shared by the mm:ss countdown timer modules.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int CfgWidth = 16;
	localparam int CfgIndexWidth = 2;

	// register indexes
	localparam logic [CfgIndexWidth-1:0] REG_SECOND_TICKS = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_COLON_OFF_TICKS = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_PAUSE_BLINK_TICKS = 2'd2;

	localparam logic [15:0] SecondTicksReset = 16'd1000;
	localparam logic [15:0] ColonOffTicksReset = 16'd500;
	localparam logic [15:0] PauseBlinkTicksReset = 16'd250;

	// commands
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP = 3'd2;
	localparam logic [2:0] CMD_PAUSE = 3'd3;
	localparam logic [2:0] CMD_ADD_MIN = 3'd4;
	localparam logic [2:0] CMD_ADD_SEC = 3'd5;
	localparam logic [2:0] CMD_SET_TIME = 3'd6;

	// run modes
	localparam logic [1:0] MODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_RUNNING = 2'd1;
	localparam logic [1:0] MODE_PAUSED = 2'd2;

	localparam logic [6:0] MaxMinutes = 7'd99;
	localparam logic [5:0] MaxSeconds = 6'd59;
	localparam logic [15:0] TickSat = 16'hFFFF;

	// floor(x/60) for signed sums: bias by SecBiasQ*60 to stay positive,
	// then multiply by the reciprocal 2^20/60 rounded up (exact below 23k)
	localparam logic [10:0] SecBiasQ = 11'd137;
	localparam logic [15:0] SecBias = 16'd8220;
	localparam logic [14:0] RecipMul = 15'd17477;
	localparam int RecipShift = 20;

	typedef struct packed {
		logic [15:0] second_ticks;
		logic [15:0] colon_off_ticks;
		logic [15:0] pause_blink_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [13:0] delta;
		logic [7:0]  new_minutes;
		logic [7:0]  new_seconds;
		logic        minutes_edited;
		logic        seconds_edited;
	} item_t;

	typedef struct packed {
		logic [1:0]  run_state;
		logic [6:0]  minute_count;
		logic [5:0]  second_count;
		logic [15:0] elapsed_ticks;
		logic        colon_lit;
		logic        minutes_hidden;
		logic        seconds_hidden;
	} state_t;

	typedef struct packed {
		logic [6:0] minutes_now;
		logic [5:0] seconds_now;
		logic [1:0] run_mode;
		logic       colon_shown;
		logic       minutes_blanked;
		logic       seconds_blanked;
		logic       limit_hit;
		logic       accepted;
		logic       display_changed;
	} result_t;

endpackage

FILE: rtl/core/mct_item_if.sv
// ----------------------------------------------------------------------------
// mct_item_if
// Request channel into the countdown timer: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface mct_item_if;

	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [13:0] delta;
	logic [7:0]  new_minutes;
	logic [7:0]  new_seconds;
	logic        minutes_edited;
	logic        seconds_edited;

	modport source (
		output valid, command, delta, new_minutes, new_seconds,
			minutes_edited, seconds_edited,
		input  ready
	);

	modport sink (
		input  valid, command, delta, new_minutes, new_seconds,
			minutes_edited, seconds_edited,
		output ready
	);

endinterface

FILE: rtl/core/mct_result_if.sv
// ----------------------------------------------------------------------------
// mct_result_if
// Result channel out of the countdown timer: valid/ready plus display fields.
// ----------------------------------------------------------------------------
interface mct_result_if;

	logic       valid;
	logic       ready;
	logic [6:0] minutes_now;
	logic [5:0] seconds_now;
	logic [1:0] run_mode;
	logic       colon_shown;
	logic       minutes_blanked;
	logic       seconds_blanked;
	logic       limit_hit;
	logic       accepted;
	logic       display_changed;

	modport source (
		output valid, minutes_now, seconds_now, run_mode, colon_shown,
			minutes_blanked, seconds_blanked, limit_hit, accepted, display_changed,
		input  ready
	);

	modport sink (
		input  valid, minutes_now, seconds_now, run_mode, colon_shown,
			minutes_blanked, seconds_blanked, limit_hit, accepted, display_changed,
		output ready
	);

endinterface

FILE: rtl/core/mct_step.sv
// ----------------------------------------------------------------------------
// mct_step
// Next-state and result logic for one timer request.
// ----------------------------------------------------------------------------
module mct_step (
	input  mct_pkg::cfg_t    cfg,
	input  mct_pkg::state_t  cur,
	input  mct_pkg::item_t   req,
	output mct_pkg::state_t  nxt,
	output mct_pkg::result_t res
);

	import mct_pkg::*;

	logic [15:0]        tick_inc;
	logic signed [15:0] delta_x;
	logic signed [15:0] min_sum;
	logic signed [15:0] sec_sum;
	logic [14:0]        sec_biased;
	logic [29:0]        recip_prod;
	logic [9:0]         quot_biased;
	logic [15:0]        quot_x60;
	logic [14:0]        sec_rem;
	logic signed [10:0] quot;
	logic signed [11:0] min_carry;
	logic [6:0]         dec_min;
	logic [5:0]         dec_sec;
	logic               limit;
	logic               acc;

	assign tick_inc = (cur.elapsed_ticks == TickSat) ? cur.elapsed_ticks
		: cur.elapsed_ticks + 16'd1;

	assign delta_x = $signed({{2{req.delta[13]}}, req.delta});
	assign min_sum = $signed({9'd0, cur.minute_count}) + delta_x;

	// floored divide of seconds + delta by 60
	assign sec_sum = $signed({10'd0, cur.second_count}) + delta_x + $signed(SecBias);
	assign sec_biased = sec_sum[14:0];
	assign recip_prod = {15'd0, sec_biased} * {15'd0, RecipMul};
	assign quot_biased = recip_prod[29:RecipShift];
	assign quot_x60 = {quot_biased, 6'd0} - {4'd0, quot_biased, 2'd0};
	assign sec_rem = sec_biased - quot_x60[14:0];
	assign quot = $signed({1'b0, quot_biased}) - $signed(SecBiasQ);
	assign min_carry = $signed({5'd0, cur.minute_count}) + $signed({quot[10], quot});

	// one-second decrement, holding at 00:00
	always_comb begin
		dec_min = cur.minute_count;
		dec_sec = cur.second_count;
		if (cur.second_count != 6'd0) begin
			dec_sec = cur.second_count - 6'd1;
		end else if (cur.minute_count != 7'd0) begin
			dec_min = cur.minute_count - 7'd1;
			dec_sec = MaxSeconds;
		end
	end

	always_comb begin
		nxt = cur;
		limit = 1'b0;
		acc = 1'b0;
		case (req.command)
			CMD_TICK: begin
				if (cur.run_state == MODE_RUNNING) begin
					nxt.elapsed_ticks = tick_inc;
					if (tick_inc >= cfg.colon_off_ticks) begin
						nxt.colon_lit = 1'b0;
					end
					if (tick_inc >= cfg.second_ticks) begin
						nxt.elapsed_ticks = tick_inc - cfg.second_ticks;
						nxt.colon_lit = 1'b1;
						nxt.minute_count = dec_min;
						nxt.second_count = dec_sec;
						if (dec_min == 7'd0 && dec_sec == 6'd0) begin
							nxt.run_state = MODE_STOPPED;
						end
					end
				end else if (cur.run_state == MODE_PAUSED) begin
					nxt.elapsed_ticks = tick_inc;
					if (tick_inc >= cfg.pause_blink_ticks) begin
						nxt.elapsed_ticks = 16'd0;
						nxt.colon_lit = ~cur.colon_lit;
						// hidden follows the new colon: hidden when colon goes off
						if (!req.minutes_edited) nxt.minutes_hidden = cur.colon_lit;
						if (!req.seconds_edited) nxt.seconds_hidden = cur.colon_lit;
					end
				end
			end
			CMD_START: begin
				nxt.run_state = MODE_RUNNING;
				nxt.elapsed_ticks = 16'd0;
				nxt.colon_lit = 1'b1;
				nxt.minutes_hidden = 1'b0;
				nxt.seconds_hidden = 1'b0;
			end
			CMD_STOP: begin
				nxt.run_state = MODE_STOPPED;
				nxt.colon_lit = 1'b1;
				nxt.minutes_hidden = 1'b0;
				nxt.seconds_hidden = 1'b0;
			end
			CMD_PAUSE: begin
				nxt.run_state = MODE_PAUSED;
				nxt.elapsed_ticks = 16'd0;
				nxt.colon_lit = 1'b1;
				nxt.minutes_hidden = 1'b0;
				nxt.seconds_hidden = 1'b0;
			end
			CMD_ADD_MIN: begin
				if (min_sum > $signed({9'd0, MaxMinutes})) begin
					nxt.minute_count = MaxMinutes;
					limit = 1'b1;
				end else if (min_sum < 16'sd0) begin
					nxt.minute_count = 7'd0;
					limit = 1'b1;
				end else begin
					nxt.minute_count = min_sum[6:0];
				end
			end
			CMD_ADD_SEC: begin
				if (quot == 11'sd0) begin
					nxt.second_count = sec_rem[5:0];
				end else if (min_carry > $signed({5'd0, MaxMinutes})) begin
					nxt.minute_count = MaxMinutes;
					nxt.second_count = MaxSeconds;
					limit = 1'b1;
				end else if (min_carry < 12'sd0) begin
					nxt.minute_count = 7'd0;
					nxt.second_count = 6'd0;
					limit = 1'b1;
				end else begin
					nxt.minute_count = min_carry[6:0];
					nxt.second_count = sec_rem[5:0];
				end
			end
			CMD_SET_TIME: begin
				if (req.new_minutes <= {1'b0, MaxMinutes} &&
						req.new_seconds <= {2'b0, MaxSeconds}) begin
					nxt.minute_count = req.new_minutes[6:0];
					nxt.second_count = req.new_seconds[5:0];
					acc = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.minutes_now = nxt.minute_count;
		res.seconds_now = nxt.second_count;
		res.run_mode = nxt.run_state;
		res.colon_shown = nxt.colon_lit;
		res.minutes_blanked = nxt.minutes_hidden;
		res.seconds_blanked = nxt.seconds_hidden;
		res.limit_hit = limit;
		res.accepted = acc;
		res.display_changed = (nxt.minute_count != cur.minute_count) ||
			(nxt.second_count != cur.second_count) ||
			(nxt.colon_lit != cur.colon_lit) ||
			(nxt.minutes_hidden != cur.minutes_hidden) ||
			(nxt.seconds_hidden != cur.seconds_hidden);
	end

endmodule

FILE: rtl/core/mmss_countdown_timer.sv
// ----------------------------------------------------------------------------
// mmss_countdown_timer
// mm:ss countdown timer with run, stop and pause modes and blink control.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel (valid/ready): command, delta, new time, edit flags.
//            A tick command stands for one millisecond.
//   result - one result per request (valid/ready): time, mode, colon and blank
//            flags, saturation and set-time status, display change flag.
//   cfg_*  - write port for second_ticks, colon_off_ticks, pause_blink_ticks;
//            write only while no request is in flight.
// Path: a request taken into the input register moves on to the result register
//   once that register is free (one input register, one result register).
// Throughput: one request per cycle while the result side takes one per cycle;
//   the timer state updates as the input register hands over to the result
//   register, so back-to-back requests see each other's effect.
// Stall: while the result register holds an untaken result, the input register
//   keeps its request and item.ready falls once it is full.
// Reset: arst_n clears the timer to 00:00 stopped, colon shown, and loads
//   the register defaults 1000, 500 and 250.
// ----------------------------------------------------------------------------
module mmss_countdown_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mct_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [mct_pkg::CfgWidth-1:0]      cfg_data,
	mct_item_if.sink                          item,
	mct_result_if.source                      result
);

	import mct_pkg::*;

	`include "mmss_countdown_timer_assert.svh"

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.second_ticks <= SecondTicksReset;
			cfg_q.colon_off_ticks <= ColonOffTicksReset;
			cfg_q.pause_blink_ticks <= PauseBlinkTicksReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SECOND_TICKS: cfg_q.second_ticks <= cfg_data;
				REG_COLON_OFF_TICKS: cfg_q.colon_off_ticks <= cfg_data;
				REG_PAUSE_BLINK_TICKS: cfg_q.pause_blink_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.command <= item.command;
			item_s1.delta <= item.delta;
			item_s1.new_minutes <= item.new_minutes;
			item_s1.new_seconds <= item.new_seconds;
			item_s1.minutes_edited <= item.minutes_edited;
			item_s1.seconds_edited <= item.seconds_edited;
		end
	end

	mct_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.req (item_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.run_state <= MODE_STOPPED;
			state_q.minute_count <= 7'd0;
			state_q.second_count <= 6'd0;
			state_q.elapsed_ticks <= 16'd0;
			state_q.colon_lit <= 1'b1;
			state_q.minutes_hidden <= 1'b0;
			state_q.seconds_hidden <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = res_valid_q;
	assign result.minutes_now = res_q.minutes_now;
	assign result.seconds_now = res_q.seconds_now;
	assign result.run_mode = res_q.run_mode;
	assign result.colon_shown = res_q.colon_shown;
	assign result.minutes_blanked = res_q.minutes_blanked;
	assign result.seconds_blanked = res_q.seconds_blanked;
	assign result.limit_hit = res_q.limit_hit;
	assign result.accepted = res_q.accepted;
	assign result.display_changed = res_q.display_changed;

	`MCT_ASSERT(a_time_range, (state_q.minute_count <= MaxMinutes) && (state_q.second_count <= MaxSeconds), "time out of range")
	`MCT_ASSERT(a_stopped_shows_all, (state_q.run_state != MODE_STOPPED) || (state_q.colon_lit && !state_q.minutes_hidden && !state_q.seconds_hidden), "stopped timer hides part of the display")
	`MCT_ASSERT(a_running_digits_shown, (state_q.run_state != MODE_RUNNING) || (!state_q.minutes_hidden && !state_q.seconds_hidden), "digits blanked while running")
	`MCT_ASSERT_NEXT(a_request_held, item.valid && item.ready, valid_s1, "taken request lost from input register")

endmodule
